/* rtl/core/hsfd_pkg.sv */
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and the CRC-8 helper of the humidity sensor frame
// decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    // CRC-8 over each 16-bit word: polynomial 0x31, seed 0xFF
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Frame byte positions
    localparam int unsigned POS_W = 3;
    localparam logic [POS_W-1:0] POS_T_MSB = 3'd0;
    localparam logic [POS_W-1:0] POS_T_LSB = 3'd1;
    localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_H_MSB = 3'd3;
    localparam logic [POS_W-1:0] POS_H_LSB = 3'd4;
    localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;
    localparam logic [POS_W-1:0] POS_LAST  = POS_H_CRC;

    // Scaling: value = floor(scale * raw / 65535), temperature minus offset
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned TEMP_PROD_W = 31;   // 17500 * 65535 < 2^31
    localparam int unsigned HUM_PROD_W  = 30;   // 10000 * 65535 < 2^30
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

    // One received byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    // One decoded measurement
    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic               status;
    } out_item_t;

    // Completed frame, handed from the byte decoder to the scaler
    typedef struct packed {
        logic [TEMP_PROD_W-1:0] temp_prod;
        logic [HUM_PROD_W-1:0]  hum_prod;
        logic                   crc_fail;
    } frame_t;

    // Eight-bit unrolled CRC-8 update, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/core/hsfd_if.sv */
// ----------------------------------------------------------------------------
// hsfd_if
// Valid/ready stream channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface hsfd_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/hsfd_frame.sv */
// ----------------------------------------------------------------------------
// hsfd_frame
// Byte position tracking, per-word CRC-8 check and word capture. On the last
// byte of a frame it registers the scaling products and the CRC verdict.
// ----------------------------------------------------------------------------
module hsfd_frame (
    input  logic           clk,
    input  logic           rst_n,
    hsfd_if.sink           frame_in,
    output hsfd_pkg::frame_t frame,
    output logic           frame_valid,
    input  logic           frame_take
);
    import hsfd_pkg::*;

    logic [POS_W-1:0]  byte_position_reg, byte_position_next;
    logic [7:0]        running_crc_reg, running_crc_next;
    logic [WORD_W-1:0] temperature_word_reg, temperature_word_next;
    logic [WORD_W-1:0] humidity_word_reg, humidity_word_next;
    logic              checksum_failed_reg, checksum_failed_next;
    logic              frame_valid_reg;
    frame_t            frame_reg;

    logic [POS_W-1:0]  pos;
    logic [7:0]        b;
    logic              accept;
    logic              crc_bad;

    // Frame register is free or drains this cycle
    assign frame_in.ready = !frame_valid_reg || frame_take;
    assign accept = frame_in.valid && frame_in.ready;
    assign b      = frame_in.data.data_byte;

    // Effective position: frame start forces byte 0
    assign pos = (frame_in.data.frame_start || byte_position_reg > POS_LAST)
                 ? POS_T_MSB : byte_position_reg;
    assign crc_bad = (running_crc_reg != b);

    // Per-byte state update
    always_comb
    begin
        running_crc_next      = running_crc_reg;
        temperature_word_next = temperature_word_reg;
        humidity_word_next    = humidity_word_reg;
        checksum_failed_next  = checksum_failed_reg;
        unique case (pos)
            POS_T_MSB:
            begin
                checksum_failed_next  = 1'b0;
                running_crc_next      = crc8_byte(CRC_INIT, b);
                temperature_word_next = {b, 8'h00};
            end
            POS_T_LSB:
            begin
                running_crc_next      = crc8_byte(running_crc_reg, b);
                temperature_word_next = {temperature_word_reg[15:8], b};
            end
            POS_T_CRC:
            begin
                if (crc_bad)
                    checksum_failed_next = 1'b1;
            end
            POS_H_MSB:
            begin
                running_crc_next   = crc8_byte(CRC_INIT, b);
                humidity_word_next = {b, 8'h00};
            end
            POS_H_LSB:
            begin
                running_crc_next   = crc8_byte(running_crc_reg, b);
                humidity_word_next = {humidity_word_reg[15:8], b};
            end
            POS_H_CRC:
            begin
                if (crc_bad)
                    checksum_failed_next = 1'b1;
            end
            default:
            begin
                checksum_failed_next = checksum_failed_reg;
            end
        endcase
        byte_position_next = (pos == POS_LAST) ? POS_T_MSB : pos + 3'd1;
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg    <= POS_T_MSB;
            running_crc_reg      <= CRC_INIT;
            temperature_word_reg <= '0;
            humidity_word_reg    <= '0;
            checksum_failed_reg  <= 1'b0;
            frame_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                byte_position_reg    <= byte_position_next;
                running_crc_reg      <= running_crc_next;
                temperature_word_reg <= temperature_word_next;
                humidity_word_reg    <= humidity_word_next;
                checksum_failed_reg  <= checksum_failed_next;
            end
            if (accept && pos == POS_LAST)
                frame_valid_reg <= 1'b1;
            else if (frame_take)
                frame_valid_reg <= 1'b0;
        end
    end

    // Products of the finished words; both words are final at the last byte
    always_ff @(posedge clk)
    begin
        if (accept && pos == POS_LAST)
        begin
            frame_reg.temp_prod <= TEMP_PROD_W'(temperature_word_reg)
                                   * TEMP_PROD_W'(TEMP_SCALE);
            frame_reg.hum_prod  <= HUM_PROD_W'(humidity_word_reg)
                                   * HUM_PROD_W'(HUM_SCALE);
            frame_reg.crc_fail  <= checksum_failed_next;
        end
    end

    assign frame       = frame_reg;
    assign frame_valid = frame_valid_reg;

    // Position never leaves the six-byte frame
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_position_reg <= POS_LAST)
        else $error("byte position out of range");

    // A completed frame is only raised by the last byte
    a_frame_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_valid_reg) |-> $past(accept) && $past(pos) == POS_LAST)
        else $error("frame raised without last byte");

    // A pending frame is not lost before it is taken
    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid_reg && !frame_take |=> frame_valid_reg && $stable(frame_reg))
        else $error("pending frame dropped or changed");

endmodule

/* rtl/core/hsfd_scale.sv */
// ----------------------------------------------------------------------------
// hsfd_scale
// Divides the registered products by 65535 with a reciprocal correction,
// applies the temperature offset and the error zeroing, and holds the result.
// ----------------------------------------------------------------------------
module hsfd_scale (
    input  logic             clk,
    input  logic             rst_n,
    input  hsfd_pkg::frame_t frame,
    input  logic             frame_valid,
    output logic             frame_take,
    hsfd_if.source           result
);
    import hsfd_pkg::*;

    logic              out_valid_reg;
    out_item_t         out_reg, out_next;
    logic [TEMP_PROD_W:0] temp_sum;
    logic [HUM_PROD_W:0]  hum_sum;
    logic [14:0]       temp_q;
    logic [13:0]       hum_q;
    logic signed [15:0] temp_val;

    // Output register is free or drains this cycle
    assign frame_take = frame_valid && (!out_valid_reg || result.ready);

    // floor(p / 65535) = (p + (p >> 16) + 1) >> 16 for these ranges
    assign temp_sum = (TEMP_PROD_W+1)'(frame.temp_prod)
                    + (TEMP_PROD_W+1)'(frame.temp_prod[TEMP_PROD_W-1:16])
                    + (TEMP_PROD_W+1)'(1);
    assign hum_sum  = (HUM_PROD_W+1)'(frame.hum_prod)
                    + (HUM_PROD_W+1)'(frame.hum_prod[HUM_PROD_W-1:16])
                    + (HUM_PROD_W+1)'(1);
    assign temp_q   = temp_sum[30:16];
    assign hum_q    = hum_sum[29:16];
    assign temp_val = $signed({1'b0, temp_q}) - TEMP_OFFSET;

    // Result item, zeroed on checksum error
    always_comb
    begin
        if (frame.crc_fail)
        begin
            out_next.temperature_centi = '0;
            out_next.humidity_centi    = '0;
            out_next.status            = STATUS_CRC_ERR;
        end
        else
        begin
            out_next.temperature_centi = temp_val[14:0];
            out_next.humidity_centi    = hum_q;
            out_next.status            = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (frame_take)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
            out_reg <= out_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // Error results carry zero values
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == STATUS_CRC_ERR |->
        out_reg.temperature_centi == '0 && out_reg.humidity_centi == '0)
        else $error("error result with nonzero values");

    // Good results stay within the sensor range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == STATUS_OK |->
        out_reg.humidity_centi <= 14'd10000
        && out_reg.temperature_centi >= -15'sd4500
        && out_reg.temperature_centi <= 15'sd13000)
        else $error("scaled value out of range");

endmodule

/* rtl/core/humidity_sensor_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_top
// Decodes six-byte temperature/humidity frames into scaled, CRC-checked
// measurements.
// ----------------------------------------------------------------------------
// Accepts one frame byte per clock with no bubbles: each byte's CRC-8 update
// (polynomial 0x31, seed 0xFF, restarted per word) is a single unrolled step,
// and the scaling uses one constant multiplier per value. The sixth byte of a
// frame produces one result: the products are registered in the frame stage,
// then the divide by 65535 and offset are registered in the output stage.
// Bytes keep flowing while a result waits, since the frame register and the
// output register each buffer one finished frame; input ready drops only
// when both are full and the output is stalled.
// frame_start forces the byte to be frame byte 0 and drops a partial frame.
// On a CRC mismatch in either word the result has status 1 and zero values.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_top (
    input  logic   clk,
    input  logic   rst_n,
    hsfd_if.sink   frame_in,
    hsfd_if.source result
);
    import hsfd_pkg::*;

    frame_t frame;
    logic   frame_valid;
    logic   frame_take;

    // Byte decode, CRC check and products
    hsfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_in    (frame_in),
        .frame       (frame),
        .frame_valid (frame_valid),
        .frame_take  (frame_take)
    );

    // Reciprocal divide, offset and output register
    hsfd_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame),
        .frame_valid (frame_valid),
        .frame_take  (frame_take),
        .result      (result)
    );

endmodule
